// ===== rtl/assert_macros.svh =====
// Assertion macros for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ===== rtl/npps_pkg.sv =====
// Types and constants for the non-preemptive priority scheduler.
package npps_pkg;

  localparam int ARR_W     = 12;
  localparam int BUR_W     = 12;
  localparam int PRI_W     = 8;
  localparam int JOB_IDX_W = 6;
  localparam int TIME_W    = 20;
  localparam int SUM_W     = 26;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  typedef struct packed {
    logic [ARR_W-1:0] arrival_time;
    logic [BUR_W-1:0] burst_time;
    logic [PRI_W-1:0] job_priority;
    logic             last_job;
  } npps_in_t;

  typedef struct packed {
    logic [JOB_IDX_W-1:0] job_index;
    logic [TIME_W-1:0]    start_time;
    logic [TIME_W-1:0]    completion_time;
    logic [TIME_W-1:0]    turnaround_time;
    logic [TIME_W-1:0]    waiting_time;
    logic [SUM_W-1:0]     turnaround_sum;
    logic [SUM_W-1:0]     waiting_sum;
    logic                 last_result;
  } npps_out_t;

  // One stored job.
  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [PRI_W-1:0] prio;
  } npps_job_t;

  // Best-so-far candidate travelling down the cell chain.
  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic                 ready;
    logic [JOB_IDX_W-1:0] index;
    npps_job_t            job;
  } npps_tok_t;

  // Per-cell strobes from the sequencer.
  typedef struct packed {
    logic wr;
    logic clr;
  } npps_cell_ctl_t;

endpackage

// ===== rtl/nonpreemptive_priority_scheduler_unit.sv =====
// Non-preemptive priority scheduler: loads a set of jobs one beat at a time into a row of
// MAX_JOBS job cells; the beat marked last_job starts a run from time zero that emits one
// result beat per dispatch, in dispatch order, with start, completion, turnaround and waiting
// times and running sums. Lowest priority number wins among arrived jobs, ties to the earlier
// arrival, then the lower load index; an idle processor jumps to the earliest pending arrival.
// Completion saturates at 2^20-1, waiting floors at zero and the sums saturate at 2^26-1.
// For each dispatch the candidate ripples through the chain one cell per cycle, then three
// arithmetic steps follow. Jobs beyond MAX_JOBS in a set are dropped. The result register
// lets the next scan proceed while a beat waits to be taken; after the final beat of a set
// the block loads again at once.
module nonpreemptive_priority_scheduler_unit import npps_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  output logic      job_ready,
  input  npps_in_t  job,
  output logic      res_valid,
  input  logic      res_ready,
  output npps_out_t res
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_COMP,
    ST_DIFF,
    ST_PUSH
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  job_count;
  logic [CNT_W-1:0]  done_cnt;
  logic [TIME_W-1:0] cur_time;
  logic [SUM_W-1:0]  tsum;
  logic [SUM_W-1:0]  wsum;
  logic              launch;

  npps_tok_t         win;
  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] comp_r;
  logic [ARR_W:0]    ab_r;
  logic [TIME_W-1:0] tat_r;
  logic [TIME_W-1:0] wt_r;

  npps_tok_t             chain [MAX_JOBS+1];
  npps_cell_ctl_t        ctl   [MAX_JOBS];
  logic [MAX_JOBS-1:0]   pending;
  npps_job_t             wr_job;

  logic              load_go;
  logic              push_go;
  logic              res_last;
  logic [TIME_W-1:0] start_c;
  logic [TIME_W:0]   comp_sum;
  logic [TIME_W-1:0] comp_c;
  logic [SUM_W:0]    tsum_add;
  logic [SUM_W:0]    wsum_add;
  logic [SUM_W-1:0]  tsum_next;
  logic [SUM_W-1:0]  wsum_next;

  assign job_ready = (state == ST_LOAD);
  assign load_go   = job_valid && job_ready && (job_count < CNT_W'(MAX_JOBS));
  assign push_go   = (state == ST_PUSH) && (!res_valid || res_ready);
  assign res_last  = ((done_cnt + CNT_W'(1)) == job_count);

  assign wr_job.arrival = job.arrival_time;
  assign wr_job.burst   = job.burst_time;
  assign wr_job.prio    = job.job_priority;

  // Chain head: an empty candidate, tagged valid on the launch cycle.
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = launch;
  end

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    assign ctl[i].wr  = load_go && (job_count == CNT_W'(i));
    assign ctl[i].clr = push_go && (win.index[IDX_W-1:0] == IDX_W'(i));

    npps_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl[i]),
      .wr_job  (wr_job),
      .cur_time(cur_time),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .pending (pending[i])
    );
  end

  // Not-ready winner means time jumps to its arrival.
  assign start_c  = win.ready ? cur_time : TIME_W'(win.job.arrival);
  assign comp_sum = {1'b0, start_c} + (TIME_W+1)'(win.job.burst);
  assign comp_c   = comp_sum[TIME_W] ? TIME_MAX : comp_sum[TIME_W-1:0];

  assign tsum_add  = {1'b0, tsum} + (SUM_W+1)'(tat_r);
  assign wsum_add  = {1'b0, wsum} + (SUM_W+1)'(wt_r);
  assign tsum_next = (tsum_add > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : tsum_add[SUM_W-1:0];
  assign wsum_next = (wsum_add > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : wsum_add[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      job_count <= '0;
      done_cnt  <= '0;
      cur_time  <= '0;
      tsum      <= '0;
      wsum      <= '0;
      launch    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      launch <= 1'b0;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (job_valid) begin
            if (load_go) begin
              job_count <= job_count + CNT_W'(1);
            end
            if (job.last_job) begin
              launch <= 1'b1;
              state  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // candidate has left the last cell
          if (chain[MAX_JOBS].valid) begin
            win   <= chain[MAX_JOBS];
            state <= ST_COMP;
          end
        end
        ST_COMP: begin
          start_r <= start_c;
          comp_r  <= comp_c;
          ab_r    <= (ARR_W+1)'(win.job.arrival) + (ARR_W+1)'(win.job.burst);
          state   <= ST_DIFF;
        end
        ST_DIFF: begin
          // comp >= arrival always holds; waiting floors at zero after saturation
          tat_r <= comp_r - TIME_W'(win.job.arrival);
          wt_r  <= (comp_r >= TIME_W'(ab_r)) ? comp_r - TIME_W'(ab_r) : '0;
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push_go) begin
            res_valid           <= 1'b1;
            res.job_index       <= win.index;
            res.start_time      <= start_r;
            res.completion_time <= comp_r;
            res.turnaround_time <= tat_r;
            res.waiting_time    <= wt_r;
            res.turnaround_sum  <= tsum_next;
            res.waiting_sum     <= wsum_next;
            res.last_result     <= res_last;
            if (res_last) begin
              job_count <= '0;
              done_cnt  <= '0;
              cur_time  <= '0;
              tsum      <= '0;
              wsum      <= '0;
              state     <= ST_LOAD;
            end else begin
              done_cnt <= done_cnt + CNT_W'(1);
              cur_time <= comp_r;
              tsum     <= tsum_next;
              wsum     <= wsum_next;
              launch   <= 1'b1;
              state    <= ST_SCAN;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // A finished scan always names a job that is still pending.
  `ASSERT_HOLDS(a_winner_pending, chain[MAX_JOBS].valid,
                chain[MAX_JOBS].found && pending[chain[MAX_JOBS].index[IDX_W-1:0]])
  // Pending cells track jobs loaded but not yet dispatched.
  `ASSERT_HOLDS(a_pending_tally, 1'b1,
                $countones(pending) == (int'(job_count) - int'(done_cnt)))
  // The final dispatch returns the block to an empty set.
  `ASSERT_NEXT(a_set_wraps, push_go && res_last,
               state == ST_LOAD && job_count == '0 && cur_time == '0 && pending == '0)
  // Time never runs backwards within a set.
  `ASSERT_NEXT(a_time_forward, push_go && !res_last, cur_time >= $past(cur_time))

endmodule

// ===== rtl/npps_cell.sv =====
// One job slot of the scheduler chain: holds a job and compares it to the passing candidate.
module npps_cell import npps_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  npps_cell_ctl_t    ctl,
  input  npps_job_t         wr_job,
  input  logic [TIME_W-1:0] cur_time,
  input  npps_tok_t         tok_in,
  output npps_tok_t         tok_out,
  output logic              pending
);

  npps_job_t job;
  npps_tok_t tok_next;
  logic      own_ready;
  logic      own_better;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      job <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (ctl.wr) begin
      pending <= 1'b1;
    end else if (ctl.clr) begin
      pending <= 1'b0;
    end
  end

  assign own_ready = (TIME_W'(job.arrival) <= cur_time);

  // Ready jobs rank by priority then arrival; if none is ready, by arrival then
  // priority. Full ties keep the incoming (lower index) candidate.
  always_comb begin
    own_better = 1'b0;
    if (!tok_in.found) begin
      own_better = 1'b1;
    end else if (own_ready && !tok_in.ready) begin
      own_better = 1'b1;
    end else if (own_ready && tok_in.ready) begin
      own_better = (job.prio < tok_in.job.prio) ||
                   ((job.prio == tok_in.job.prio) && (job.arrival < tok_in.job.arrival));
    end else if (!own_ready && !tok_in.ready) begin
      own_better = (job.arrival < tok_in.job.arrival) ||
                   ((job.arrival == tok_in.job.arrival) && (job.prio < tok_in.job.prio));
    end
  end

  always_comb begin
    tok_next = tok_in;
    if (pending && own_better) begin
      tok_next.found = 1'b1;
      tok_next.ready = own_ready;
      tok_next.index = JOB_IDX_W'(CELL_IDX);
      tok_next.job   = job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule
